>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the frame builder design.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define DSFB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define DSFB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/dsfb_pkg.sv
// ---------------------------------------------------------------------------
// Frame builder package
// Line byte constants, command codes and the job record passed from the
// front end to the byte sequencer.
// ---------------------------------------------------------------------------
package dsfb_pkg;

  // Framing bytes on the serial line.
  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] SEQ_BYTE = 8'h00;
  localparam logic [7:0] DLE_BYTE = 8'h10;
  localparam logic [7:0] ETX_BYTE = 8'h03;

  // Input command codes.
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  // Job kinds.
  typedef logic [1:0] job_kind_t;
  localparam job_kind_t JOB_START   = 2'd0;
  localparam job_kind_t JOB_PAYLOAD = 2'd1;
  localparam job_kind_t JOB_ERROR   = 2'd2;

  // One classified input beat, with everything needed to expand it.
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data_byte;    // opcode for a start, raw byte for a payload
    logic [7:0] length_byte;  // payload length for a start
    logic [7:0] check_byte;   // block check after this beat
    logic       stuff;        // a second DLE follows the length or data byte
    logic       close;        // the trailer follows this beat
  } job_t;

endpackage

>>> design/dsfb_front.sv
// ---------------------------------------------------------------------------
// Frame builder front end
// Accepts input beats, tracks the open frame and the running check, and
// turns each beat into a job for the byte sequencer.
// ---------------------------------------------------------------------------
module dsfb_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_cmd,
  input  logic [7:0]      in_opcode,
  input  logic [7:0]      in_payload_length,
  input  logic [7:0]      in_payload_byte,
  output logic            push_valid,
  input  logic            push_ready,
  output dsfb_pkg::job_t  push_job
);

  logic       frame_open_r, frame_open_nxt;
  logic [7:0] remaining_r, remaining_nxt;
  logic [7:0] check_r, check_nxt;
  logic [7:0] remaining_dec;
  logic       accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;
  assign remaining_dec = remaining_r - 8'd1;

  // Classify the beat and work out the frame state it leaves behind.
  always_comb begin
    frame_open_nxt = frame_open_r;
    remaining_nxt  = remaining_r;
    check_nxt      = check_r;
    push_job       = '0;
    if (in_cmd == dsfb_pkg::CMD_START) begin
      push_job.kind        = dsfb_pkg::JOB_START;
      push_job.data_byte   = in_opcode;
      push_job.length_byte = in_payload_length;
      push_job.check_byte  = dsfb_pkg::SEQ_BYTE ^ in_opcode ^ in_payload_length;
      push_job.stuff       = (in_payload_length == dsfb_pkg::DLE_BYTE);
      push_job.close       = (in_payload_length == 8'd0);
      check_nxt            = push_job.check_byte;
      remaining_nxt        = in_payload_length;
      frame_open_nxt       = !push_job.close;
    end else if (!frame_open_r) begin
      push_job.kind = dsfb_pkg::JOB_ERROR;
    end else begin
      push_job.kind       = dsfb_pkg::JOB_PAYLOAD;
      push_job.data_byte  = in_payload_byte;
      push_job.check_byte = check_r ^ in_payload_byte;
      push_job.stuff      = (in_payload_byte == dsfb_pkg::DLE_BYTE);
      push_job.close      = (remaining_dec == 8'd0);
      check_nxt           = push_job.check_byte;
      remaining_nxt       = remaining_dec;
      frame_open_nxt      = !push_job.close;
    end
  end

  // Frame state advances only on an accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      remaining_r  <= 8'd0;
      check_r      <= 8'd0;
    end else if (accept) begin
      frame_open_r <= frame_open_nxt;
      remaining_r  <= remaining_nxt;
      check_r      <= check_nxt;
    end
  end

endmodule

>>> design/dsfb_queue.sv
// ---------------------------------------------------------------------------
// Frame builder job queue
// Small first-in first-out buffer of jobs between the front end and the
// byte sequencer.
// ---------------------------------------------------------------------------
module dsfb_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  dsfb_pkg::job_t  push_job,
  output logic            head_valid,
  input  logic            pop,
  output dsfb_pkg::job_t  head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dsfb_pkg::job_t   slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  // Pointer and occupancy update with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> design/dsfb_back.sv
// ---------------------------------------------------------------------------
// Frame builder byte sequencer
// Expands the job at the head of the queue into line bytes, one per cycle
// while the output is not stalled, into a registered output stage.
// ---------------------------------------------------------------------------
module dsfb_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  dsfb_pkg::job_t  head_job,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_line_byte,
  output logic            out_byte_valid,
  output logic            out_frame_done,
  output logic            out_misuse_error,
  output logic            out_run_last
);

  // Sequencer steps; STEP_HEAD means the first step of the head job.
  localparam logic [3:0] STEP_HEAD = 4'd0;
  localparam logic [3:0] STEP_STX  = 4'd1;
  localparam logic [3:0] STEP_SEQ  = 4'd2;
  localparam logic [3:0] STEP_OPC  = 4'd3;
  localparam logic [3:0] STEP_LEN  = 4'd4;
  localparam logic [3:0] STEP_DAT  = 4'd5;
  localparam logic [3:0] STEP_STF  = 4'd6;
  localparam logic [3:0] STEP_CHK  = 4'd7;
  localparam logic [3:0] STEP_DLE  = 4'd8;
  localparam logic [3:0] STEP_ETX  = 4'd9;
  localparam logic [3:0] STEP_ERR  = 4'd10;

  logic [3:0] step_r, step_nxt;
  logic [3:0] cur_step;
  logic [3:0] next_step;
  logic       last_step;
  logic [7:0] cur_byte;
  logic       load;
  logic       emit;

  logic       out_valid_r;
  logic [7:0] line_byte_r;
  logic       byte_valid_r;
  logic       frame_done_r;
  logic       misuse_error_r;
  logic       run_last_r;

  assign load = !out_valid_r || out_ready;
  assign emit = head_valid && load;
  assign pop  = emit && last_step;

  // Resolve the current step and its successor.
  always_comb begin
    cur_step = step_r;
    if (step_r == STEP_HEAD) begin
      case (head_job.kind)
        dsfb_pkg::JOB_START:   cur_step = STEP_STX;
        dsfb_pkg::JOB_PAYLOAD: cur_step = STEP_DAT;
        default:               cur_step = STEP_ERR;
      endcase
    end
    next_step = STEP_HEAD;
    last_step = 1'b0;
    cur_byte  = 8'd0;
    case (cur_step)
      STEP_STX: begin
        cur_byte  = dsfb_pkg::STX_BYTE;
        next_step = STEP_SEQ;
      end
      STEP_SEQ: begin
        cur_byte  = dsfb_pkg::SEQ_BYTE;
        next_step = STEP_OPC;
      end
      STEP_OPC: begin
        cur_byte  = head_job.data_byte;
        next_step = STEP_LEN;
      end
      STEP_LEN, STEP_DAT: begin
        cur_byte = (cur_step == STEP_LEN) ? head_job.length_byte : head_job.data_byte;
        if (head_job.stuff) begin
          next_step = STEP_STF;
        end else if (head_job.close) begin
          next_step = STEP_CHK;
        end else begin
          last_step = 1'b1;
        end
      end
      STEP_STF: begin
        cur_byte = dsfb_pkg::DLE_BYTE;
        if (head_job.close) begin
          next_step = STEP_CHK;
        end else begin
          last_step = 1'b1;
        end
      end
      STEP_CHK: begin
        cur_byte  = head_job.check_byte;
        next_step = STEP_DLE;
      end
      STEP_DLE: begin
        cur_byte  = dsfb_pkg::DLE_BYTE;
        next_step = STEP_ETX;
      end
      STEP_ETX: begin
        cur_byte  = dsfb_pkg::ETX_BYTE;
        last_step = 1'b1;
      end
      default: begin
        last_step = 1'b1;
      end
    endcase
    step_nxt = step_r;
    if (emit) begin
      step_nxt = last_step ? STEP_HEAD : next_step;
    end
  end

  // Step register and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_HEAD;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output beat payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      line_byte_r    <= cur_byte;
      byte_valid_r   <= (cur_step != STEP_ERR);
      frame_done_r   <= (cur_step == STEP_ETX);
      misuse_error_r <= (cur_step == STEP_ERR);
      run_last_r     <= last_step;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_line_byte    = line_byte_r;
  assign out_byte_valid   = byte_valid_r;
  assign out_frame_done   = frame_done_r;
  assign out_misuse_error = misuse_error_r;
  assign out_run_last     = run_last_r;

endmodule

>>> design/dle_stuffed_frame_builder.sv
// ---------------------------------------------------------------------------
// DLE stuffed frame builder
// Turns start and payload beats into a byte-stuffed command frame with an
// XOR block check.
// ---------------------------------------------------------------------------
// Usage:
// The input channel takes one beat per command: a start beat (cmd 0) with
// opcode and payload length, or a payload beat (cmd 1) with one raw byte.
// The output channel delivers line bytes, one beat each, with flags for
// frame end, misuse and the last byte caused by an input beat.
// A start beat yields 4 or 5 bytes (7 when the length is zero); a
// payload beat yields 1 or 2 bytes, plus 3 trailer bytes on the last one.
// An accepted beat is written into the job queue; its first byte is then
// loaded from the queue head into the output register. The byte sequencer
// sends one byte per cycle while the receiver does not stall, and the
// sequencer's one-byte-per-cycle rate sets the sustained throughput.
// A job queue of QUEUE_DEPTH entries lets input beats be accepted while
// the receiver stalls; in_ready drops only when that queue is full.
// Synchronous reset closes any open frame, clears the check and empties
// the queue and output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dle_stuffed_frame_builder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  input  logic [7:0] in_opcode,
  input  logic [7:0] in_payload_length,
  input  logic [7:0] in_payload_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_line_byte,
  output logic       out_byte_valid,
  output logic       out_frame_done,
  output logic       out_misuse_error,
  output logic       out_run_last
);

  logic           push_valid;
  logic           push_ready;
  dsfb_pkg::job_t push_job;
  logic           head_valid;
  logic           pop;
  dsfb_pkg::job_t head_job;

  // Front end: classification and frame state.
  dsfb_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_opcode         (in_opcode),
    .in_payload_length (in_payload_length),
    .in_payload_byte   (in_payload_byte),
    .push_valid        (push_valid),
    .push_ready        (push_ready),
    .push_job          (push_job)
  );

  // Job queue between the two halves.
  dsfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .head_valid (head_valid),
    .pop        (pop),
    .head_job   (head_job)
  );

  // Back end: byte sequencer and output register.
  dsfb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_job         (head_job),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_line_byte    (out_line_byte),
    .out_byte_valid   (out_byte_valid),
    .out_frame_done   (out_frame_done),
    .out_misuse_error (out_misuse_error),
    .out_run_last     (out_run_last)
  );

  // The closing ETX is always a real byte and ends its input beat's run.
  `DSFB_ASSERT(a_etx_ends_run,
               out_valid && out_frame_done |->
                 out_run_last && out_byte_valid && (out_line_byte == dsfb_pkg::ETX_BYTE),
               "ETX beat must be the last byte of its run")
  // A misuse beat stands alone and carries no line byte.
  `DSFB_ASSERT(a_misuse_alone, out_valid && out_misuse_error |-> out_run_last && !out_byte_valid,
               "misuse beat must be a lone non-byte result")
  // A job leaves the queue only while the output register takes a beat.
  `DSFB_ASSERT(a_pop_on_load, pop |-> head_valid && (!out_valid || out_ready),
               "queue popped without an output load")
  // The output register is empty in the cycle after a reset edge.
  `DSFB_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid after reset")

endmodule

>>> bench/dle_stuffed_frame_builder_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// DLE stuffed frame builder test
// Drives start and payload beats into the frame builder and checks every
// line byte it sends against a cycle-free model of the framing rules:
// header, DLE stuffing, XOR block check, trailer, misuse errors and
// abandoned frames. Directed cases come first, then random frames under
// several patterns of sender idling and receiver stalls.
// ---------------------------------------------------------------------------
module dle_stuffed_frame_builder_test;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int REPORT_LIMIT   = 10;

  // One line byte with its flags, as seen on the output channel.
  typedef struct packed {
    logic [7:0] line_byte;
    logic       byte_valid;
    logic       frame_done;
    logic       misuse_error;
    logic       run_last;
  } line_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_cmd = 1'b0;
  logic [7:0] in_opcode = 8'h00;
  logic [7:0] in_payload_length = 8'h00;
  logic [7:0] in_payload_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_line_byte;
  logic       out_byte_valid;
  logic       out_frame_done;
  logic       out_misuse_error;
  logic       out_run_last;

  // Model state of the framer.
  logic       model_frame_open = 1'b0;
  logic [7:0] model_bytes_left = 8'h00;
  logic [7:0] model_check = 8'h00;

  line_beat_t line_beats_due[$];
  int         error_count = 0;
  int         items_sent = 0;
  int         idle_cycles = 0;
  int         sender_idle_pct = 0;
  int         recv_stall_pct = 0;
  line_beat_t seen_beat;
  line_beat_t due_beat;

  dle_stuffed_frame_builder i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_opcode         (in_opcode),
    .in_payload_length (in_payload_length),
    .in_payload_byte   (in_payload_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_line_byte     (out_line_byte),
    .out_byte_valid    (out_byte_valid),
    .out_frame_done    (out_frame_done),
    .out_misuse_error  (out_misuse_error),
    .out_run_last      (out_run_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic line_beat_t make_line_beat(input logic [7:0] data, input logic valid,
                                                input logic done, input logic err);
    line_beat_t b;
    b.line_byte    = data;
    b.byte_valid   = valid;
    b.frame_done   = done;
    b.misuse_error = err;
    b.run_last     = 1'b0;
    return b;
  endfunction

  // Work out the line bytes that one accepted beat causes and queue them.
  task automatic expand_command(input logic cmd, input logic [7:0] opcode,
                                input logic [7:0] len, input logic [7:0] pbyte);
    line_beat_t run[8];
    int         n;
    logic       close;
    n = 0;
    close = 1'b0;
    if (cmd == dsfb_pkg::CMD_START) begin
      // A start drops any open frame and emits a fresh header.
      run[0] = make_line_beat(dsfb_pkg::STX_BYTE, 1'b1, 1'b0, 1'b0);
      run[1] = make_line_beat(dsfb_pkg::SEQ_BYTE, 1'b1, 1'b0, 1'b0);
      run[2] = make_line_beat(opcode, 1'b1, 1'b0, 1'b0);
      run[3] = make_line_beat(len, 1'b1, 1'b0, 1'b0);
      n = 4;
      if (len == dsfb_pkg::DLE_BYTE) begin
        run[n] = make_line_beat(dsfb_pkg::DLE_BYTE, 1'b1, 1'b0, 1'b0);
        n++;
      end
      model_check = dsfb_pkg::SEQ_BYTE ^ opcode ^ len;
      model_bytes_left = len;
      model_frame_open = 1'b1;
      close = (len == 8'h00);
    end else if (!model_frame_open) begin
      run[0] = make_line_beat(8'h00, 1'b0, 1'b0, 1'b1);
      n = 1;
    end else begin
      run[0] = make_line_beat(pbyte, 1'b1, 1'b0, 1'b0);
      n = 1;
      if (pbyte == dsfb_pkg::DLE_BYTE) begin
        run[n] = make_line_beat(dsfb_pkg::DLE_BYTE, 1'b1, 1'b0, 1'b0);
        n++;
      end
      model_check = model_check ^ pbyte;
      model_bytes_left = model_bytes_left - 8'd1;
      close = (model_bytes_left == 8'h00);
    end
    // The trailer carries the check unstuffed, then DLE and ETX.
    if (close) begin
      run[n]     = make_line_beat(model_check, 1'b1, 1'b0, 1'b0);
      run[n + 1] = make_line_beat(dsfb_pkg::DLE_BYTE, 1'b1, 1'b0, 1'b0);
      run[n + 2] = make_line_beat(dsfb_pkg::ETX_BYTE, 1'b1, 1'b1, 1'b0);
      n += 3;
      model_frame_open = 1'b0;
      model_bytes_left = 8'h00;
    end
    run[n - 1].run_last = 1'b1;
    for (int i = 0; i < n; i++) begin
      line_beats_due.push_back(run[i]);
    end
  endtask

  // Present one beat at a falling edge, hold it until accepted, then predict.
  task automatic send_beat(input logic cmd, input logic [7:0] opcode,
                           input logic [7:0] len, input logic [7:0] pbyte);
    @(negedge clk);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid          <= 1'b1;
    in_cmd            <= cmd;
    in_opcode         <= opcode;
    in_payload_length <= len;
    in_payload_byte   <= pbyte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expand_command(cmd, opcode, len, pbyte);
    items_sent++;
  endtask

  // Unused fields of a beat carry random values.
  task automatic send_start(input logic [7:0] opcode, input logic [7:0] len);
    send_beat(dsfb_pkg::CMD_START, opcode, len, 8'($urandom));
  endtask

  task automatic send_payload(input logic [7:0] pbyte);
    send_beat(dsfb_pkg::CMD_PAYLOAD, 8'($urandom), 8'($urandom), pbyte);
  endtask

  // Random byte that hits the DLE value often enough to exercise stuffing.
  function automatic logic [7:0] pick_line_data();
    if ($urandom_range(99) < 15) return dsfb_pkg::DLE_BYTE;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'h00;
    if (r < 20) return dsfb_pkg::DLE_BYTE;
    if (r < 25) return 8'($urandom_range(40, 17));
    return 8'($urandom_range(6, 1));
  endfunction

  // Send a start and the first sent_count payload bytes of its frame. A full
  // frame may have its last byte chosen so that the block check equals DLE.
  task automatic send_frame(input logic [7:0] len, input int sent_count,
                            input logic check_is_dle);
    logic [7:0] opcode;
    logic [7:0] check;
    logic [7:0] data;
    opcode = ($urandom_range(9) == 0) ? dsfb_pkg::DLE_BYTE : 8'($urandom);
    check = dsfb_pkg::SEQ_BYTE ^ opcode ^ len;
    send_start(opcode, len);
    for (int i = 0; i < sent_count; i++) begin
      data = pick_line_data();
      if (check_is_dle && i == int'(len) - 1) data = check ^ dsfb_pkg::DLE_BYTE;
      check = check ^ data;
      send_payload(data);
    end
  endtask

  // Payload beats with no open frame: right after reset nothing is open.
  task automatic test_misuse_after_reset();
    send_payload(8'h00);
    send_payload(8'hFF);
  endtask

  // Zero length closes the frame at once; a payload after it is misuse.
  task automatic test_zero_length();
    send_start(8'hFF, 8'h00);
    send_start(8'h00, 8'h00);
    send_payload(8'h10);
  endtask

  // DLE opcode is not stuffed, a DLE payload byte is, a DLE check is not.
  task automatic test_stuffing();
    send_start(dsfb_pkg::DLE_BYTE, 8'h02);
    send_payload(dsfb_pkg::DLE_BYTE);
    send_payload(8'h12);
  endtask

  // A new start drops the open frame, including the stuffed DLE length.
  task automatic test_abandoned_frame();
    send_start(8'hA5, dsfb_pkg::DLE_BYTE);
    send_payload(8'h3C);
    send_start(8'h81, 8'hFF);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_start(8'h5A, 8'h01);
    send_payload(8'hFF);
  endtask

  // One complete frame of the largest length.
  task automatic test_longest_frame();
    send_frame(8'hFF, 255, 1'b0);
  endtask

  // Mostly well-formed frames, with cut-off frames, strays and raw noise.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int item_count);
    int   stop_at;
    int   r;
    logic [7:0] len;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    stop_at = items_sent + item_count;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      len = pick_length();
      if (r < 70) begin
        send_frame(len, int'(len), $urandom_range(3) == 0);
      end else if (r < 85) begin
        if (len == 8'h00) len = 8'h03;
        send_frame(len, $urandom_range(int'(len) - 1), 1'b0);
      end else if (r < 92) begin
        send_payload(pick_line_data());
      end else begin
        send_beat(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  // Receiver readiness changes at the falling edge.
  always @(negedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted output beat with the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_beat = {out_line_byte, out_byte_valid, out_frame_done, out_misuse_error,
                   out_run_last};
      if (line_beats_due.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("%0t: unexpected beat byte=%h valid=%b done=%b err=%b last=%b", $realtime,
                   seen_beat.line_byte, seen_beat.byte_valid, seen_beat.frame_done,
                   seen_beat.misuse_error, seen_beat.run_last);
        end
      end else begin
        due_beat = line_beats_due.pop_front();
        if (seen_beat.line_byte !== due_beat.line_byte ||
            seen_beat.byte_valid !== due_beat.byte_valid ||
            seen_beat.frame_done !== due_beat.frame_done ||
            seen_beat.misuse_error !== due_beat.misuse_error ||
            seen_beat.run_last !== due_beat.run_last) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("%0t: mismatch expected byte=%h valid=%b done=%b err=%b last=%b",
                     $realtime, due_beat.line_byte, due_beat.byte_valid,
                     due_beat.frame_done, due_beat.misuse_error, due_beat.run_last);
            $display("%0t:          actual byte=%h valid=%b done=%b err=%b last=%b",
                     $realtime, seen_beat.line_byte, seen_beat.byte_valid,
                     seen_beat.frame_done, seen_beat.misuse_error, seen_beat.run_last);
          end
        end
      end
    end
  end

  // End the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_misuse_after_reset();
    test_zero_length();
    test_stuffing();
    test_abandoned_frame();
    test_longest_frame();
    test_random_traffic(0, 0, 45);
    test_random_traffic(75, 0, 45);
    test_random_traffic(0, 75, 45);
    test_random_traffic(11, 11, 44);

    @(negedge clk);
    in_valid <= 1'b0;

    // Let the output drain, then watch for stray beats.
    while (line_beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    error_count += line_beats_due.size();

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
